/* design/tlsm_pkg.sv */
// ----------------------------------------------------------------------------
// tlsm_pkg
// Shared widths, command codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tlsm_pkg;

    localparam int LIST_DEPTH   = 512;
    localparam int TABLE_DEPTH  = 262144;
    localparam int VALUE_W      = 48;
    localparam int SUM_W        = VALUE_W + 1;
    localparam int WANT_W       = VALUE_W + 2;
    localparam int LIST_IDX_W   = $clog2(LIST_DEPTH);
    localparam int LIST_LEN_W   = $clog2(LIST_DEPTH + 1);
    localparam int TABLE_IDX_W  = $clog2(TABLE_DEPTH);
    localparam int TABLE_LEN_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_CLEAR    = 3'd0,
        CMD_APPEND_A = 3'd1,
        CMD_APPEND_B = 3'd2,
        CMD_APPEND_C = 3'd3,
        CMD_BUILD    = 3'd4,
        CMD_QUERY    = 3'd5
    } cmd_t;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_BUILD_CHK = 8'b0000_0010,
        ST_BUILD_WR  = 8'b0000_0100,
        ST_Q_CCHK    = 8'b0000_1000,
        ST_Q_CSUB    = 8'b0001_0000,
        ST_Q_TCHK    = 8'b0010_0000,
        ST_Q_TCMP    = 8'b0100_0000,
        ST_DONE      = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic build_init;
        logic build_wr;
        logic q_init;
        logic q_sub;
        logic q_cmp;
        logic q_next_c;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic build_done;
        logic c_done;
        logic scan_done;
        logic found;
        logic out_free;
    } status_t;

endpackage

/* design/tlsm_ctrl.sv */
// ----------------------------------------------------------------------------
// tlsm_ctrl
// Command decoder and sequencer for build and query passes.
// ----------------------------------------------------------------------------
module tlsm_ctrl import tlsm_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [2:0]    s_cmd,
    input  status_t       status,
    output ctrl_t         ctrl
);

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_cmd)
                        CMD_CLEAR: ctrl.clear = 1'b1;
                        CMD_APPEND_A, CMD_APPEND_B, CMD_APPEND_C: ctrl.append = 1'b1;
                        CMD_BUILD: begin
                            ctrl.build_init = 1'b1;
                            state_next      = ST_BUILD_CHK;
                        end
                        CMD_QUERY: begin
                            ctrl.q_init = 1'b1;
                            state_next  = ST_Q_CCHK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_BUILD_CHK: begin
                state_next = status.build_done ? ST_IDLE : ST_BUILD_WR;
            end
            ST_BUILD_WR: begin
                ctrl.build_wr = 1'b1;
                state_next    = ST_BUILD_CHK;
            end
            ST_Q_CCHK: begin
                state_next = status.c_done ? ST_DONE : ST_Q_CSUB;
            end
            ST_Q_CSUB: begin
                ctrl.q_sub = 1'b1;
                state_next = ST_Q_TCHK;
            end
            ST_Q_TCHK: begin
                priority if (status.found) begin
                    state_next = ST_DONE;
                end else if (status.scan_done) begin
                    ctrl.q_next_c = 1'b1;
                    state_next    = ST_Q_CCHK;
                end else begin
                    state_next = ST_Q_TCMP;
                end
            end
            ST_Q_TCMP: begin
                ctrl.q_cmp = 1'b1;
                state_next = ST_Q_TCHK;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* design/tlsm_dp.sv */
// ----------------------------------------------------------------------------
// tlsm_dp
// List and table memories, counters, pair adder, target compare and the
// result register.
// ----------------------------------------------------------------------------
module tlsm_dp import tlsm_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ctrl_t                      ctrl,
    output status_t                    status,
    input  logic [2:0]                 s_cmd,
    input  logic signed [VALUE_W-1:0]  s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_found,
    output logic                       m_overflow_seen
);

    logic signed [VALUE_W-1:0] a_mem [LIST_DEPTH];
    logic signed [VALUE_W-1:0] b_mem [LIST_DEPTH];
    logic signed [VALUE_W-1:0] c_mem [LIST_DEPTH];
    logic signed [SUM_W-1:0]   t_mem [TABLE_DEPTH];

    logic signed [VALUE_W-1:0] a_rd_reg, b_rd_reg, c_rd_reg;
    logic signed [SUM_W-1:0]   t_rd_reg;

    logic [LIST_LEN_W-1:0]  len_a_reg, len_b_reg, len_c_reg;
    logic [LIST_LEN_W-1:0]  i_reg, j_reg, ci_reg;
    logic [TABLE_LEN_W-1:0] tlen_reg, k_reg;
    logic                   ovf_reg, found_reg, m_valid_reg, m_found_reg, m_ovf_reg;
    logic signed [VALUE_W-1:0] target_reg;
    logic signed [WANT_W-1:0]  want_reg;

    logic wr_a, wr_b, wr_c, full;
    logic signed [SUM_W-1:0] pair_sum;

    assign full = (s_cmd == CMD_APPEND_A) ? (len_a_reg == LIST_LEN_W'(LIST_DEPTH)) :
                  (s_cmd == CMD_APPEND_B) ? (len_b_reg == LIST_LEN_W'(LIST_DEPTH)) :
                                            (len_c_reg == LIST_LEN_W'(LIST_DEPTH));
    assign wr_a = ctrl.append && !full && (s_cmd == CMD_APPEND_A);
    assign wr_b = ctrl.append && !full && (s_cmd == CMD_APPEND_B);
    assign wr_c = ctrl.append && !full && (s_cmd == CMD_APPEND_C);
    assign pair_sum = SUM_W'(a_rd_reg) + SUM_W'(b_rd_reg);

    // memories: one write port, registered read at the running index
    always_ff @(posedge aclk) begin
        if (wr_a) a_mem[len_a_reg[LIST_IDX_W-1:0]] <= s_value;
        a_rd_reg <= a_mem[i_reg[LIST_IDX_W-1:0]];
    end
    always_ff @(posedge aclk) begin
        if (wr_b) b_mem[len_b_reg[LIST_IDX_W-1:0]] <= s_value;
        b_rd_reg <= b_mem[j_reg[LIST_IDX_W-1:0]];
    end
    always_ff @(posedge aclk) begin
        if (wr_c) c_mem[len_c_reg[LIST_IDX_W-1:0]] <= s_value;
        c_rd_reg <= c_mem[ci_reg[LIST_IDX_W-1:0]];
    end
    always_ff @(posedge aclk) begin
        if (ctrl.build_wr) t_mem[tlen_reg[TABLE_IDX_W-1:0]] <= pair_sum;
        t_rd_reg <= t_mem[k_reg[TABLE_IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_a_reg   <= '0;
            len_b_reg   <= '0;
            len_c_reg   <= '0;
            tlen_reg    <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            m_ovf_reg   <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            ci_reg      <= '0;
            k_reg       <= '0;
            found_reg   <= 1'b0;
        end else begin
            if (ctrl.clear) begin
                len_a_reg <= '0;
                len_b_reg <= '0;
                len_c_reg <= '0;
                tlen_reg  <= '0;
            end
            if (ctrl.append && full) ovf_reg <= 1'b1;
            if (wr_a) len_a_reg <= len_a_reg + 1'b1;
            if (wr_b) len_b_reg <= len_b_reg + 1'b1;
            if (wr_c) len_c_reg <= len_c_reg + 1'b1;
            if (ctrl.build_init) begin
                i_reg    <= '0;
                j_reg    <= '0;
                tlen_reg <= '0;
            end
            if (ctrl.build_wr) begin
                tlen_reg <= tlen_reg + 1'b1;
                if (j_reg + 1'b1 == len_b_reg) begin
                    j_reg <= '0;
                    i_reg <= i_reg + 1'b1;
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            if (ctrl.q_init) begin
                ci_reg    <= '0;
                found_reg <= 1'b0;
            end
            if (ctrl.q_sub) k_reg <= '0;
            if (ctrl.q_cmp) begin
                if (WANT_W'(t_rd_reg) == want_reg) found_reg <= 1'b1;
                k_reg <= k_reg + 1'b1;
            end
            if (ctrl.q_next_c) ci_reg <= ci_reg + 1'b1;
            // freeze the flag with the word so later appends leave it alone
            if (ctrl.out_load) m_ovf_reg <= ovf_reg;
            if (ctrl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (ctrl.q_init) target_reg <= s_value;
        if (ctrl.q_sub) want_reg <= WANT_W'(target_reg) - WANT_W'(c_rd_reg);
        if (ctrl.out_load) m_found_reg <= found_reg;
    end

    assign status.build_done = (i_reg >= len_a_reg) || (len_b_reg == '0) ||
                               (tlen_reg == TABLE_LEN_W'(TABLE_DEPTH));
    assign status.c_done     = (ci_reg >= len_c_reg);
    assign status.scan_done  = (k_reg >= tlen_reg);
    assign status.found      = found_reg;
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_overflow_seen = m_ovf_reg;

endmodule

/* design/three_list_sum_membership_core.sv */
// ----------------------------------------------------------------------------
// three_list_sum_membership_core
// Holds lists A, B and C, builds the table of pair sums of A and B, and
// answers whether a target equals some c of C plus some pair sum.
// ----------------------------------------------------------------------------
//
//  channel | ports                         | carries
//  --------+-------------------------------+-------------------------------
//  input   | s_valid s_ready s_cmd s_value | command word and signed value
//  result  | m_valid m_ready m_found       | one word per query
//          | m_overflow_seen               |
//
// Passes: clear, append and unused codes are taken while idle. Build alternates
// a check state and a write state for each pair sum, set by the single table
// write port. A query checks and subtracts each scanned c, then alternates a
// table check and a compare state per entry through the table memory's one
// read port; the scan stops at the first hit.
// Reset: synchronous, active low; clears list and table lengths and the
// overflow flag. Memories are not cleared, only entries below a length are read.
// Stalls: a finished result waits in the output register; the next words are
// taken meanwhile, and a later query holds in its last state until it drains.
//
module three_list_sum_membership_core import tlsm_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_cmd,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_found,
    output logic                      m_overflow_seen
);

    ctrl_t   ctrl;
    status_t status;

    // sequencer: decode words, step build and query passes
    tlsm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .status  (status),
        .ctrl    (ctrl)
    );

    // storage, counters and compare
    tlsm_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .status          (status),
        .s_cmd           (s_cmd),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_overflow_seen (m_overflow_seen)
    );

endmodule

/* design/tlsm_checker.sv */
// ----------------------------------------------------------------------------
// tlsm_checker
// Port-level checks on the membership core.
// ----------------------------------------------------------------------------
module tlsm_checker import tlsm_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic [2:0]                s_cmd,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_found,
    input logic                      m_overflow_seen
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_overflow_seen))
        else $error("result dropped while stalled");

    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd != CMD_QUERY && !m_valid |=> !m_valid)
        else $error("result without a query");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_cmd == CMD_QUERY || s_cmd == CMD_BUILD) |=> !s_ready)
        else $error("took a word during a pass");

    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_overflow_seen |=> m_overflow_seen)
        else $error("overflow flag cleared");

endmodule

bind three_list_sum_membership_core tlsm_checker u_tlsm_checker (.*);

/* verif/three_list_sum_membership_core_tb.sv */
// ----------------------------------------------------------------------------
// three_list_sum_membership_core_tb
// Self-checking bench for the three-list sum membership core. Drives command
// words, keeps a behavioral copy of the lists and the pair-sum table, and
// checks every query answer in order. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module three_list_sum_membership_core_tb;
    import tlsm_pkg::*;

    // Codes the block must ignore.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam longint VAL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint VAL_MIN = -64'sh0000_8000_0000_0000;

    typedef struct {
        logic [2:0]         cmd;
        logic [VALUE_W-1:0] value;
    } cmd_word_t;

    typedef struct {
        logic found;
        logic overflow_seen;
    } answer_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [2:0]                s_cmd;
    logic signed [VALUE_W-1:0] s_value;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_found;
    logic                      m_overflow_seen;

    three_list_sum_membership_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_overflow_seen (m_overflow_seen)
    );

    // Pending command words and the answers still owed by the block.
    cmd_word_t pending_words[$];
    answer_t   owed_answers[$];

    // Behavioral copy of the block state.
    longint list_a[$];
    longint list_b[$];
    longint list_c[$];
    longint sum_table[$];
    bit     overflow_flag;

    int  total_words;
    int  accepted_words;
    int  checked_answers;
    int  hit_answers;
    int  mismatches;
    int  send_gap;
    int  take_stall;
    bit  quiet;

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic longint sext(logic [VALUE_W-1:0] raw);
        return longint'(signed'(raw));
    endfunction

    task automatic put_word(logic [2:0] cmd, longint value);
        cmd_word_t w;
        w.cmd   = cmd;
        w.value = value[VALUE_W-1:0];
        pending_words.push_back(w);
    endtask

    // Append to a list copy, honoring depth and the sticky overflow.
    task automatic append_to(ref longint lst[$], input longint v);
        if (lst.size() >= LIST_DEPTH) begin
            overflow_flag = 1'b1;
        end else begin
            lst.push_back(v);
        end
    endtask

    // Form all pair sums in A-major order, sort and drop duplicates.
    task automatic build_sums();
        longint raw[$];
        raw = {};
        foreach (list_a[i]) begin
            foreach (list_b[j]) begin
                if (raw.size() < TABLE_DEPTH) raw.push_back(list_a[i] + list_b[j]);
            end
        end
        raw.sort();
        sum_table = {};
        foreach (raw[i]) begin
            if (sum_table.size() == 0 || raw[i] != sum_table[sum_table.size()-1])
                sum_table.push_back(raw[i]);
        end
    endtask

    function automatic bit target_reachable(longint target);
        longint hits[$];
        foreach (list_c[i]) begin
            hits = sum_table.find_first with (item == target - list_c[i]);
            if (hits.size() > 0) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Update the state copy for one accepted word and queue any answer.
    task automatic apply_word(logic [2:0] cmd, logic [VALUE_W-1:0] raw);
        longint  v;
        answer_t a;
        v = sext(raw);
        case (cmd)
            CMD_CLEAR: begin
                list_a = {};
                list_b = {};
                list_c = {};
                sum_table = {};
            end
            CMD_APPEND_A: append_to(list_a, v);
            CMD_APPEND_B: append_to(list_b, v);
            CMD_APPEND_C: append_to(list_c, v);
            CMD_BUILD:    build_sums();
            CMD_QUERY: begin
                a.found         = target_reachable(v);
                a.overflow_seen = overflow_flag;
                owed_answers.push_back(a);
            end
            default: ;
        endcase
    endtask

    // Random value: mostly small so sums meet, sometimes extreme or wide.
    function automatic longint pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX - $urandom_range(0, 3);
            1:       return VAL_MIN + $urandom_range(0, 3);
            2:       return sext(VALUE_W'({$urandom(), $urandom()}));
            default: return longint'($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    // Driver: present the next pending word, hold it until accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_cmd    <= CMD_CLEAR;
            s_value  <= '0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_word(s_cmd, s_value);
                accepted_words <= accepted_words + 1;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    cmd_word_t w;
                    w = pending_words.pop_front();
                    s_valid <= 1'b1;
                    s_cmd   <= w.cmd;
                    s_value <= w.value;
                    if (!quiet && $urandom_range(0, 4) == 0)
                        send_gap <= $urandom_range(1, 18);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: take answers with random stall bursts and compare in order.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            take_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_answers.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected answer: found=%0b overflow_seen=%0b",
                                 m_found, m_overflow_seen);
                end else begin
                    answer_t a;
                    a = owed_answers.pop_front();
                    checked_answers = checked_answers + 1;
                    if (a.found) hit_answers = hit_answers + 1;
                    if (m_found !== a.found || m_overflow_seen !== a.overflow_seen) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("answer %0d: expected found=%0b ovf=%0b, got found=%0b ovf=%0b",
                                     checked_answers, a.found, a.overflow_seen,
                                     m_found, m_overflow_seen);
                    end
                end
            end
            if (take_stall > 0) begin
                take_stall <= take_stall - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    take_stall <= $urandom_range(1, 18);
            end
        end
    end

    // Drop idling for the tail of the run.
    always @(posedge aclk) quiet <= (pending_words.size() < 20);

    initial begin
        int n_a;
        int n_b;
        int n_c;
        int n_q;
        longint t;

        aresetn         = 1'b0;
        quiet           = 1'b0;
        overflow_flag   = 1'b0;
        accepted_words  = 0;
        checked_answers = 0;
        hit_answers     = 0;
        mismatches      = 0;

        // Directed: empty query, extremes, duplicates, ignored codes.
        put_word(CMD_QUERY, 0);
        put_word(CMD_APPEND_A, VAL_MAX);
        put_word(CMD_APPEND_A, VAL_MIN);
        put_word(CMD_APPEND_B, VAL_MAX);
        put_word(CMD_APPEND_B, VAL_MIN);
        put_word(CMD_APPEND_B, 0);
        put_word(CMD_QUERY, 0);                 // table not built yet
        put_word(CMD_BUILD, 0);
        put_word(CMD_QUERY, 0);                 // C still empty
        put_word(CMD_APPEND_C, 0);
        put_word(CMD_APPEND_C, VAL_MIN);
        put_word(CMD_QUERY, -1);                // MAX+MIN+0
        put_word(CMD_QUERY, VAL_MAX);
        put_word(CMD_QUERY, 12345);
        put_word(CMD_SPARE_6, VAL_MAX);
        put_word(CMD_SPARE_7, -1);
        put_word(CMD_APPEND_A, 7);              // table unchanged until rebuild
        put_word(CMD_QUERY, 7);
        put_word(CMD_BUILD, 0);
        put_word(CMD_QUERY, 7);
        put_word(CMD_CLEAR, 0);
        put_word(CMD_APPEND_A, 1);
        put_word(CMD_BUILD, 0);                 // B empty, table empty
        put_word(CMD_QUERY, 1);

        // Random: well-formed fill/build/query sessions, some noise.
        for (int s = 0; s < 6; s++) begin
            longint pa[$];
            longint pb[$];
            longint pc[$];
            pa = {};
            pb = {};
            pc = {};
            if ($urandom_range(0, 5) != 0) put_word(CMD_CLEAR, pick_value());
            n_a = $urandom_range(0, 5);
            n_b = $urandom_range(0, 5);
            n_c = $urandom_range(0, 5);
            for (int i = 0; i < n_a; i++) begin
                t = pick_value(); pa.push_back(t); put_word(CMD_APPEND_A, t);
            end
            for (int i = 0; i < n_b; i++) begin
                t = pick_value(); pb.push_back(t); put_word(CMD_APPEND_B, t);
            end
            for (int i = 0; i < n_c; i++) begin
                t = pick_value(); pc.push_back(t); put_word(CMD_APPEND_C, t);
            end
            if ($urandom_range(0, 7) != 0) put_word(CMD_BUILD, pick_value());
            n_q = $urandom_range(1, 4);
            for (int q = 0; q < n_q; q++) begin
                if (pa.size() > 0 && pb.size() > 0 && pc.size() > 0
                    && $urandom_range(0, 1) == 0)
                    t = pa[$urandom_range(0, pa.size()-1)] + pb[$urandom_range(0, pb.size()-1)]
                        + pc[$urandom_range(0, pc.size()-1)];
                else
                    t = pick_value();
                put_word(CMD_QUERY, t);
                if ($urandom_range(0, 5) == 0)
                    put_word($urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7, pick_value());
                if ($urandom_range(0, 5) == 0) put_word(CMD_APPEND_C, pick_value());
            end
        end
        total_words = pending_words.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        wait (accepted_words == total_words);
        wait (owed_answers.size() == 0);
        // Let any build still in flight finish.
        repeat (2000) @(posedge aclk);

        $display("covered %0d command words, %0d answers checked (%0d hits)",
                 total_words, checked_answers, hit_answers);
        if (mismatches == 0 && owed_answers.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #200000000;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

endmodule
